>>> sv/ttsb_pkg.sv
package ttsb_pkg;

    localparam logic [1:0] CMD_PUT    = 2'd0;
    localparam logic [1:0] CMD_SCROLL = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] RESET_COLOR  = 8'h07;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_VIEW,
        OP_READ,
        OP_NOP
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_COPY,
        S_BLANK,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [7:0] char_code;
        logic [7:0] scroll_target;
        logic [6:0] cell_column;
        logic [4:0] cell_row;
    } t_cmd;

    typedef struct packed {
        logic [15:0] cell_entry;
        logic [6:0]  cursor_row;
        logic [6:0]  cursor_column;
        logic [6:0]  scroll_position;
    } t_result;

endpackage

>>> sv/ttsb_fifo.sv
module ttsb_fifo #(
    parameter int WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_rdata = r_mem[r_rptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wptr <= ~r_wptr;
            end
            if (pop_ok) begin
                r_rptr <= ~r_rptr;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 2'd1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

>>> sv/ttsb_front.sv
module ttsb_front #(
    parameter int SCREEN_COLUMNS,
    parameter int SCREEN_ROWS,
    parameter int STORED_ROWS
) (
    input  logic [1:0]      i_cmd,
    input  logic [7:0]      i_char_code,
    input  logic [7:0]      i_scroll_target,
    input  logic [6:0]      i_cell_column,
    input  logic [4:0]      i_cell_row,
    output ttsb_pkg::t_cmd  o_cmd
);
    import ttsb_pkg::*;

    localparam int LIMIT = (STORED_ROWS > SCREEN_ROWS) ? STORED_ROWS - SCREEN_ROWS : 0;

    logic in_range;

    assign in_range = ({3'b000, i_cell_row} < 8'(SCREEN_ROWS))
                   && ({2'b00, i_cell_column} < 9'(SCREEN_COLUMNS));

    always_comb begin
        o_cmd.char_code   = i_char_code;
        o_cmd.cell_column = i_cell_column;
        o_cmd.cell_row    = i_cell_row;
        if ({3'b000, i_scroll_target} > 11'(LIMIT)) begin
            o_cmd.scroll_target = 8'(LIMIT);
        end else begin
            o_cmd.scroll_target = i_scroll_target;
        end
        case (i_cmd)
            CMD_PUT: begin
                o_cmd.op = (i_char_code == NEWLINE_CHAR) ? OP_NEWLINE : OP_PUT;
            end
            CMD_SCROLL: begin
                o_cmd.op = OP_VIEW;
            end
            CMD_READ: begin
                o_cmd.op = in_range ? OP_READ : OP_NOP;
            end
            default: begin
                o_cmd.op = OP_NOP;
            end
        endcase
    end

endmodule

>>> sv/ttsb_back.sv
module ttsb_back #(
    parameter int SCREEN_COLUMNS,
    parameter int SCREEN_ROWS,
    parameter int STORED_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_text_color,
    input  ttsb_pkg::t_cmd    i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output ttsb_pkg::t_result o_res
);
    import ttsb_pkg::*;

    localparam int CELLS_SB  = SCREEN_COLUMNS * STORED_ROWS;
    localparam int SCR_CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int MAX_ROWS  = (STORED_ROWS > SCREEN_ROWS) ? STORED_ROWS : SCREEN_ROWS;
    localparam int CLR_N     = SCREEN_COLUMNS * MAX_ROWS;
    localparam int LIMIT     = (STORED_ROWS > SCREEN_ROWS) ? STORED_ROWS - SCREEN_ROWS : 0;
    localparam int SB_AW     = $clog2(CELLS_SB);
    localparam int SCR_AW    = (SCR_CELLS > 1) ? $clog2(SCR_CELLS) : 1;
    localparam int CNT_W     = $clog2(CLR_N);
    localparam int SRC_W     = $clog2(CLR_N + 1);
    localparam int ROW_W     = $clog2(STORED_ROWS);
    localparam int RW        = ROW_W + 1;
    localparam int CW        = (RW > 8) ? RW : 8;
    localparam int COL_W     = (SCREEN_COLUMNS > 1) ? $clog2(SCREEN_COLUMNS) : 1;
    localparam int CI_W      = COL_W + 1;

    logic [15:0] r_sb_mem  [CELLS_SB];
    logic [15:0] r_scr_mem [SCR_CELLS];

    t_state            r_state, n_state;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_view, n_view;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [SRC_W-1:0]  r_src, n_src;
    logic              r_rd, n_rd;
    logic              r_cp_valid, n_cp_valid;
    logic              r_cp_blank, n_cp_blank;
    logic [SCR_AW-1:0] r_cp_dst, n_cp_dst;
    logic [15:0]       r_sb_rdata;
    logic [15:0]       r_scr_rdata;

    logic              go;
    logic [CI_W-1:0]   col_inc;
    logic [RW-1:0]     row_inc;
    logic              advance;
    logic              wrap;
    logic              leave;
    logic              visible;
    logic [ROW_W-1:0]  view_step;

    logic              sb_we;
    logic [SB_AW-1:0]  sb_waddr;
    logic [15:0]       sb_wdata;
    logic [SB_AW-1:0]  sb_raddr;
    logic              scr_we;
    logic [SCR_AW-1:0] scr_waddr;
    logic [15:0]       scr_wdata;
    logic [SCR_AW-1:0] scr_raddr;

    assign go      = (r_state == S_IDLE) && !i_cmd_empty && !i_res_full;
    assign col_inc = {1'b0, r_col} + CI_W'(1);
    assign row_inc = {1'b0, r_row} + RW'(1);
    assign advance = (i_cmd.op == OP_NEWLINE)
                  || ((i_cmd.op == OP_PUT) && (col_inc == CI_W'(SCREEN_COLUMNS)));
    assign wrap    = advance && (int'(row_inc) >= STORED_ROWS);
    assign leave   = advance && !wrap && (row_inc >= {1'b0, r_view})
                  && (CW'(row_inc - {1'b0, r_view}) >= CW'(SCREEN_ROWS));
    assign visible = (r_row >= r_view) && (CW'(r_row - r_view) < CW'(SCREEN_ROWS));
    assign view_step = (int'(r_view) >= LIMIT) ? r_view : r_view + ROW_W'(1);
    assign scr_raddr = SCR_AW'(int'(i_cmd.cell_row) * SCREEN_COLUMNS
                              + int'(i_cmd.cell_column));
    assign sb_raddr  = r_src[SB_AW-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (int'(r_cnt) == CLR_N - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (go) begin
                    if (i_cmd.op == OP_VIEW || leave) begin
                        n_state = S_COPY;
                    end else if (i_cmd.op == OP_READ) begin
                        n_state = S_DONE;
                    end else if (wrap) begin
                        n_state = S_BLANK;
                    end
                end
            end
            S_COPY, S_BLANK: begin
                if (int'(r_cnt) == SCR_CELLS - 1) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_row      = r_row;
        n_col      = r_col;
        n_view     = r_view;
        n_cnt      = r_cnt;
        n_src      = r_src;
        n_rd       = r_rd;
        n_cp_valid = 1'b0;
        n_cp_blank = r_cp_blank;
        n_cp_dst   = r_cp_dst;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        sb_we      = 1'b0;
        sb_waddr   = SB_AW'(int'(r_row) * SCREEN_COLUMNS + int'(r_col));
        sb_wdata   = {i_text_color, i_cmd.char_code};
        scr_we     = 1'b0;
        scr_waddr  = SCR_AW'(int'(r_row - r_view) * SCREEN_COLUMNS + int'(r_col));
        scr_wdata  = {i_text_color, i_cmd.char_code};
        case (r_state)
            S_CLEAR: begin
                sb_we     = int'(r_cnt) < CELLS_SB;
                sb_waddr  = r_cnt[SB_AW-1:0];
                sb_wdata  = {RESET_COLOR, BLANK_CHAR};
                scr_we    = int'(r_cnt) < SCR_CELLS;
                scr_waddr = r_cnt[SCR_AW-1:0];
                scr_wdata = {RESET_COLOR, BLANK_CHAR};
                n_cnt     = r_cnt + CNT_W'(1);
            end
            S_IDLE: begin
                if (go) begin
                    o_cmd_pop = 1'b1;
                    n_rd      = 1'b0;
                    n_cnt     = '0;
                    case (i_cmd.op)
                        OP_PUT: begin
                            sb_we  = 1'b1;
                            scr_we = visible;
                            n_col  = col_inc[COL_W-1:0];
                        end
                        OP_VIEW: begin
                            n_view = ROW_W'(i_cmd.scroll_target);
                            n_src  = SRC_W'(int'(i_cmd.scroll_target) * SCREEN_COLUMNS);
                        end
                        OP_READ: begin
                            n_rd = 1'b1;
                        end
                        default: begin
                            n_rd = 1'b0;
                        end
                    endcase
                    if (advance) begin
                        n_col = '0;
                        if (wrap) begin
                            n_row  = '0;
                            n_view = '0;
                        end else begin
                            n_row = row_inc[ROW_W-1:0];
                            if (leave) begin
                                n_view = view_step;
                                n_src  = SRC_W'(int'(view_step) * SCREEN_COLUMNS);
                            end
                        end
                    end
                    o_res_push = (i_cmd.op == OP_NOP)
                              || ((i_cmd.op == OP_PUT || i_cmd.op == OP_NEWLINE)
                                  && !wrap && !leave);
                end
            end
            S_COPY: begin
                n_src      = r_src + SRC_W'(1);
                n_cnt      = r_cnt + CNT_W'(1);
                n_cp_valid = 1'b1;
                n_cp_dst   = r_cnt[SCR_AW-1:0];
                n_cp_blank = int'(r_src) >= CELLS_SB;
            end
            S_BLANK: begin
                scr_we    = 1'b1;
                scr_waddr = r_cnt[SCR_AW-1:0];
                scr_wdata = {i_text_color, BLANK_CHAR};
                n_cnt     = r_cnt + CNT_W'(1);
            end
            S_DONE: begin
                o_res_push = 1'b1;
            end
            default: begin
                n_cnt = '0;
            end
        endcase
        if (r_cp_valid) begin
            scr_we    = 1'b1;
            scr_waddr = r_cp_dst;
            scr_wdata = r_cp_blank ? {i_text_color, BLANK_CHAR} : r_sb_rdata;
        end
        o_res.cell_entry      = ((r_state == S_DONE) && r_rd) ? r_scr_rdata : 16'h0000;
        o_res.cursor_row      = 7'(n_row);
        o_res.cursor_column   = 7'(n_col);
        o_res.scroll_position = 7'(n_view);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_row      <= '0;
            r_col      <= '0;
            r_view     <= '0;
            r_cnt      <= '0;
            r_rd       <= 1'b0;
            r_cp_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_row      <= n_row;
            r_col      <= n_col;
            r_view     <= n_view;
            r_cnt      <= n_cnt;
            r_rd       <= n_rd;
            r_cp_valid <= n_cp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_cp_blank <= n_cp_blank;
        r_cp_dst   <= n_cp_dst;
    end

    always_ff @(posedge i_clk) begin
        if (sb_we) begin
            r_sb_mem[sb_waddr] <= sb_wdata;
        end
        r_sb_rdata <= r_sb_mem[sb_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (scr_we) begin
            r_scr_mem[scr_waddr] <= scr_wdata;
        end
        r_scr_rdata <= r_scr_mem[scr_raddr];
    end

endmodule

>>> sv/text_terminal_with_scrollback.sv
// Channel   Direction  Transfer when     Payload
// input     in         push && !full     i_cmd, i_char_code, i_scroll_target,
//                                        i_cell_column, i_cell_row
// result    out        pop && !empty     o_cell_entry, o_cursor_row,
//                                        o_cursor_column, o_scroll_position
// config    in         i_cfg_we          i_cfg_wdata (text color)
//
// A character, newline, unused command or out-of-range read is carried out in the
// idle state; an in-range cell read also passes through a done state, where the
// registered screen memory read data is returned. A scroll request, or a line
// change that moves the view, recopies the screen one cell per cycle through the
// scrollback read port; a wrap past the last stored row instead blanks the
// screen. After reset a clearing pass over SCREEN_COLUMNS * max(STORED_ROWS,
// SCREEN_ROWS) cells runs before any item is carried out. Two-entry queues on
// each side let input and result stall separately.
module text_terminal_with_scrollback #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25,
    parameter int STORED_ROWS    = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_scroll_target,
    input  logic [6:0]  i_cell_column,
    input  logic [4:0]  i_cell_row,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_cell_entry,
    output logic [6:0]  o_cursor_row,
    output logic [6:0]  o_cursor_column,
    output logic [6:0]  o_scroll_position
);
    import ttsb_pkg::*;

    logic [7:0] r_text_color;
    t_cmd       front_cmd;
    t_cmd       queued_cmd;
    logic       cmd_empty;
    logic       cmd_pop;
    t_result    res;
    t_result    head_res;
    logic       res_push;
    logic       res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= RESET_COLOR;
        end else if (i_cfg_we) begin
            r_text_color <= i_cfg_wdata;
        end
    end

    ttsb_front #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS),
        .STORED_ROWS    (STORED_ROWS)
    ) u_front (
        .i_cmd           (i_cmd),
        .i_char_code     (i_char_code),
        .i_scroll_target (i_scroll_target),
        .i_cell_column   (i_cell_column),
        .i_cell_row      (i_cell_row),
        .o_cmd           (front_cmd)
    );

    ttsb_fifo #(
        .WIDTH ($bits(t_cmd))
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_wdata (front_cmd),
        .o_empty (cmd_empty),
        .i_pop   (cmd_pop),
        .o_rdata (queued_cmd)
    );

    ttsb_back #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS),
        .STORED_ROWS    (STORED_ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text_color (r_text_color),
        .i_cmd        (queued_cmd),
        .i_cmd_empty  (cmd_empty),
        .o_cmd_pop    (cmd_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (res)
    );

    ttsb_fifo #(
        .WIDTH ($bits(t_result))
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .o_full  (res_full),
        .i_wdata (res),
        .o_empty (empty),
        .i_pop   (pop),
        .o_rdata (head_res)
    );

    assign o_cell_entry      = head_res.cell_entry;
    assign o_cursor_row      = head_res.cursor_row;
    assign o_cursor_column   = head_res.cursor_column;
    assign o_scroll_position = head_res.scroll_position;

`ifndef SYNTHESIS
    a_res_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full result queue");

    a_cmd_avail : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command popped from an empty command queue");

    a_col_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> ({2'b00, res.cursor_column} < 9'(SCREEN_COLUMNS)))
        else $error("cursor column reported beyond the last column");
`endif

endmodule
